// File: hw/rtl/ps2dl_pkg.sv
// Shared types and constants for the PS/2 device link transceiver.
package ps2dl_pkg;

  // Frame bit positions, counted down from the first data bit
  localparam logic [4:0] POS_DATA0  = 5'd10;
  localparam logic [4:0] POS_PARITY = 5'd2;
  localparam logic [4:0] POS_STOP   = 5'd1;
  localparam logic [4:0] POS_ACK    = 5'd0;

  // Reset value of the enable register
  localparam logic DEVICE_ENABLED_RST = 1'b1;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LINE = 2'd1,
    ACT_SEND = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // One input request
  typedef struct packed {
    logic [1:0] action;
    logic       clk_line;
    logic       data_line;
    logic [7:0] send_byte;
  } in_item_t;

  // One result
  typedef struct packed {
    logic       clk_drive_low;
    logic       data_drive_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_parity_bit;
    logic       send_accepted;
    logic       tx_done;
    logic       tx_aborted;
    logic       busy_res;
  } out_item_t;

  // Frame status from the core
  typedef struct packed {
    logic sending;
    logic receiving;
  } core_status_t;

endpackage

// File: hw/rtl/ps2dl_core.sv
// Link state and per-request next-state logic of the PS/2 device transceiver.
module ps2dl_core
  import ps2dl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic         device_enabled_i,
  input  in_item_t     item_i,
  output out_item_t    result_o,
  output core_status_t status_o
);

  logic       clock_released_q, clock_released_d;
  logic [4:0] bit_position_q, bit_position_d;
  logic       receiving_q, receiving_d;
  logic       sending_q, sending_d;
  logic       host_req_q, host_req_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic       rx_parity_q, rx_parity_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic       tx_parity_q, tx_parity_d;
  logic       data_low_q, data_low_d;

  logic       past_end;
  logic       rx_valid, accepted, done, aborted;
  logic [7:0] rx_b;
  logic       rx_p;
  logic [3:0] rx_pos;

  assign past_end = bit_position_q[4];
  // Data bit index of the bit being sampled: first data bit at position ten
  assign rx_pos   = POS_DATA0[3:0] - bit_position_q[3:0];

  // Next state for one request
  always_comb begin
    clock_released_d = clock_released_q;
    bit_position_d   = bit_position_q;
    receiving_d      = receiving_q;
    sending_d        = sending_q;
    host_req_d       = host_req_q;
    rx_shift_d       = rx_shift_q;
    rx_parity_d      = rx_parity_q;
    tx_shift_d       = tx_shift_q;
    tx_parity_d      = tx_parity_q;
    data_low_d       = data_low_q;
    rx_valid         = 1'b0;
    rx_b             = 8'd0;
    rx_p             = 1'b0;
    accepted         = 1'b0;
    done             = 1'b0;
    aborted          = 1'b0;

    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (sending_q || receiving_q) begin
          if (clock_released_q) begin
            if (!item_i.clk_line) begin
              // host holds the clock low: drop the frame
              aborted          = sending_q;
              clock_released_d = 1'b1;
              data_low_d       = 1'b0;
              sending_d        = 1'b0;
              receiving_d      = 1'b0;
              host_req_d       = 1'b0;
            end else if (receiving_q) begin
              if (bit_position_q == POS_ACK) begin
                data_low_d = 1'b1;
              end
              if (past_end) begin
                host_req_d       = 1'b0;
                clock_released_d = 1'b1;
                data_low_d       = 1'b0;
                receiving_d      = 1'b0;
                sending_d        = 1'b0;
                rx_valid         = 1'b1;
                rx_b             = rx_shift_q;
                rx_p             = rx_parity_q;
              end else begin
                clock_released_d = 1'b0;
              end
            end else begin
              if (past_end) begin
                clock_released_d = 1'b1;
                data_low_d       = 1'b0;
                sending_d        = 1'b0;
                receiving_d      = 1'b0;
                done             = 1'b1;
              end else begin
                clock_released_d = 1'b0;
              end
            end
          end else begin
            // rising clock: sample or shift one bit
            clock_released_d = 1'b1;
            if (receiving_q) begin
              if (bit_position_q == POS_DATA0) begin
                rx_shift_d = {7'd0, item_i.data_line};
              end else if (bit_position_q > POS_PARITY &&
                           bit_position_q < POS_DATA0) begin
                rx_shift_d = rx_shift_q | (8'(item_i.data_line) << rx_pos);
              end else if (bit_position_q == POS_PARITY) begin
                rx_parity_d = item_i.data_line;
              end
            end else begin
              if (bit_position_q > POS_PARITY &&
                  bit_position_q <= POS_DATA0) begin
                data_low_d = ~tx_shift_q[0];
                tx_shift_d = tx_shift_q >> 1;
              end else if (bit_position_q == POS_PARITY) begin
                data_low_d = tx_parity_q;
              end else if (bit_position_q == POS_STOP) begin
                data_low_d = 1'b0;
              end
            end
            bit_position_d = bit_position_q - 5'd1;
          end
        end
      end
      ACT_LINE: begin
        if (!sending_q && !receiving_q) begin
          if (!item_i.clk_line && !item_i.data_line) begin
            host_req_d = 1'b1;
          end else if (item_i.clk_line && !item_i.data_line && host_req_q) begin
            // request-to-send completed: start reception
            clock_released_d = 1'b1;
            bit_position_d   = POS_DATA0;
            host_req_d       = 1'b0;
            receiving_d      = 1'b1;
          end else begin
            host_req_d = 1'b0;
          end
        end
      end
      ACT_SEND: begin
        if (item_i.send_byte != 8'd0 && device_enabled_i && !sending_q &&
            !receiving_q && item_i.clk_line) begin
          sending_d        = 1'b1;
          tx_shift_d       = item_i.send_byte;
          tx_parity_d      = ^item_i.send_byte;
          data_low_d       = 1'b1;
          clock_released_d = 1'b0;
          bit_position_d   = POS_DATA0;
          accepted         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of this request
  always_comb begin
    result_o.clk_drive_low  = ~clock_released_d;
    result_o.data_drive_low = data_low_d;
    result_o.rx_valid       = rx_valid;
    result_o.rx_byte        = rx_b;
    result_o.rx_parity_bit  = rx_p;
    result_o.send_accepted  = accepted;
    result_o.tx_done        = done;
    result_o.tx_aborted     = aborted;
    result_o.busy_res       = sending_d | receiving_d;
  end

  assign status_o.sending   = sending_q;
  assign status_o.receiving = receiving_q;

  // Link state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_released_q <= 1'b1;
      bit_position_q   <= POS_ACK;
      receiving_q      <= 1'b0;
      sending_q        <= 1'b0;
      host_req_q       <= 1'b0;
      rx_shift_q       <= 8'd0;
      rx_parity_q      <= 1'b0;
      tx_shift_q       <= 8'd0;
      tx_parity_q      <= 1'b0;
      data_low_q       <= 1'b0;
    end else if (accept_i) begin
      clock_released_q <= clock_released_d;
      bit_position_q   <= bit_position_d;
      receiving_q      <= receiving_d;
      sending_q        <= sending_d;
      host_req_q       <= host_req_d;
      rx_shift_q       <= rx_shift_d;
      rx_parity_q      <= rx_parity_d;
      tx_shift_q       <= tx_shift_d;
      tx_parity_q      <= tx_parity_d;
      data_low_q       <= data_low_d;
    end
  end

endmodule

// File: hw/rtl/ps2_device_link_transceiver_unit.sv
// PS/2 device link transceiver: one result for every request, one request per clock cycle
// while the input is not stalled. Each request (half-bit tick, line change event or send
// request) updates the link state and its result is registered. A two-entry output
// buffer (result register plus skid register) lets requests keep flowing while one result
// waits, so the input stalls only when both entries are full. device_enabled is written
// through the configuration port (always ready) and should be changed only while idle.
module ps2_device_link_transceiver_unit
  import ps2dl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration write
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  // request channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  // result channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic         device_enabled_q;
  logic         in_accept, out_take;
  out_item_t    result;
  core_status_t status;

  logic         out_valid_q, skid_valid_q;
  out_item_t    out_item_q, skid_item_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~skid_valid_q;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_enabled_q <= DEVICE_ENABLED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      device_enabled_q <= cfg_data_i;
    end
  end

  ps2dl_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .device_enabled_i (device_enabled_q),
    .item_i           (in_item_i),
    .result_o         (result),
    .status_o         (status)
  );

  // Output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_item_q <= skid_item_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_item_q <= result;
      end else begin
        out_item_q <= result;
      end
    end
  end

  // Checks
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.sending && status.receiving))
    else $error("send and receive frames active together");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in front");

  a_done_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.tx_done && out_item_q.tx_aborted))
    else $error("transfer both finished and aborted");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && result.send_accepted) |=> status.sending)
    else $error("accepted send did not start a frame");

endmodule

// File: tb/ps2_device_link_transceiver_unit_tb.sv
// Self-checking testbench for the PS/2 device link transceiver unit.
`timescale 1ns / 100ps

module ps2_device_link_transceiver_unit_tb;
  import ps2dl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SHOWN_ERRORS = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  ps2_device_link_transceiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Link state as the testbench sees it
  bit       dev_enable;
  bit       clk_freed;
  bit [4:0] frame_pos;
  bit       rx_active;
  bit       tx_active;
  bit       rts_seen;
  bit [7:0] rx_sreg;
  bit       rx_par;
  bit [7:0] tx_sreg;
  bit       tx_par;
  bit       data_held_low;

  out_item_t pending_responses[$];

  int  requests_sent;
  int  responses_checked;
  int  error_count;
  int  frames_started;
  int  bytes_received;
  int  frames_cut;
  int  cycle_count;
  int  stall_left;
  bit  calm;

  // Gap before a request or after a result; none at all in calm stretches
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic in_item_t make_req(action_e act, bit cl, bit dl, logic [7:0] b);
    in_item_t r;
    r.action    = act;
    r.clk_line  = cl;
    r.data_line = dl;
    r.send_byte = b;
    return r;
  endfunction

  function automatic void drop_link();
    clk_freed     = 1'b1;
    data_held_low = 1'b0;
    tx_active     = 1'b0;
    rx_active     = 1'b0;
  endfunction

  // Advance the link by one request and queue the response it should give
  function automatic void predict_link_response(in_item_t req);
    out_item_t rsp;
    bit        past_end;
    past_end = frame_pos[4];
    rsp      = '0;
    case (action_e'(req.action))
      ACT_TICK: begin
        if (tx_active || rx_active) begin
          if (clk_freed) begin
            if (!req.clk_line) begin
              // host holding the clock low
              if (tx_active) begin
                rsp.tx_aborted = 1'b1;
                frames_cut++;
              end
              drop_link();
              rts_seen = 1'b0;
            end else if (rx_active) begin
              if (frame_pos == POS_ACK) data_held_low = 1'b1;
              if (past_end) begin
                rts_seen = 1'b0;
                drop_link();
                rsp.rx_valid      = 1'b1;
                rsp.rx_byte       = rx_sreg;
                rsp.rx_parity_bit = rx_par;
                bytes_received++;
              end else begin
                clk_freed = 1'b0;
              end
            end else begin
              if (past_end) begin
                drop_link();
                rsp.tx_done = 1'b1;
              end else begin
                clk_freed = 1'b0;
              end
            end
          end else begin
            clk_freed = 1'b1;
            if (rx_active) begin
              if (frame_pos == POS_DATA0) begin
                rx_sreg = {7'd0, req.data_line};
              end else if (frame_pos > POS_PARITY && frame_pos < POS_DATA0) begin
                rx_sreg = rx_sreg | (8'(req.data_line) << (POS_DATA0 - frame_pos));
              end else if (frame_pos == POS_PARITY) begin
                rx_par = req.data_line;
              end
            end else begin
              if (frame_pos > POS_PARITY && frame_pos <= POS_DATA0) begin
                data_held_low = ~tx_sreg[0];
                tx_sreg       = tx_sreg >> 1;
              end else if (frame_pos == POS_PARITY) begin
                data_held_low = tx_par;
              end else if (frame_pos == POS_STOP) begin
                data_held_low = 1'b0;
              end
            end
            frame_pos = frame_pos - 5'd1;
          end
        end
      end
      ACT_LINE: begin
        if (!tx_active && !rx_active) begin
          if (!req.clk_line && !req.data_line) begin
            rts_seen = 1'b1;
          end else if (req.clk_line && !req.data_line && rts_seen) begin
            // host request-to-send complete: start receiving
            clk_freed = 1'b1;
            frame_pos = POS_DATA0;
            rts_seen  = 1'b0;
            rx_active = 1'b1;
          end else begin
            rts_seen = 1'b0;
          end
        end
      end
      ACT_SEND: begin
        if (req.send_byte != 8'd0 && dev_enable && !tx_active && !rx_active &&
            req.clk_line) begin
          tx_active         = 1'b1;
          tx_sreg           = req.send_byte;
          tx_par            = ^req.send_byte;
          data_held_low     = 1'b1;
          clk_freed         = 1'b0;
          frame_pos         = POS_DATA0;
          rsp.send_accepted = 1'b1;
          frames_started++;
        end
      end
      default: ;
    endcase
    rsp.clk_drive_low  = ~clk_freed;
    rsp.data_drive_low = data_held_low;
    rsp.busy_res       = tx_active | rx_active;
    pending_responses.push_back(rsp);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input in_item_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_link_response(req);
    requests_sent++;
  endtask

  // Let every outstanding response come back, then idle with no request offered
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enable(input bit value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dev_enable = value;
  endtask

  // Host clocks ticks until the frame ends, optionally holding the clock low once
  task automatic clock_frame(input bit hold_low);
    int tick_no;
    int cut_at;
    tick_no = 0;
    cut_at  = $urandom_range(0, 22);
    while ((tx_active || rx_active) && tick_no < 40) begin
      send_request(make_req(ACT_TICK, !(hold_low && tick_no == cut_at),
                            1'($urandom_range(0, 1)), 8'($urandom())));
      tick_no++;
    end
  endtask

  // Special cases one at a time
  task automatic test_directed();
    send_request(make_req(ACT_NONE, 1'b1, 1'b1, 8'hFF));
    send_request(make_req(ACT_TICK, 1'b0, 1'b0, 8'h00));
    send_request(make_req(ACT_SEND, 1'b1, 1'b1, 8'h00));
    send_request(make_req(ACT_SEND, 1'b0, 1'b1, 8'hA5));
    // broken request-to-send, then a good one
    send_request(make_req(ACT_LINE, 1'b0, 1'b0, 8'h00));
    send_request(make_req(ACT_LINE, 1'b1, 1'b1, 8'h00));
    send_request(make_req(ACT_LINE, 1'b1, 1'b0, 8'h00));
    send_request(make_req(ACT_LINE, 1'b0, 1'b0, 8'h00));
    send_request(make_req(ACT_LINE, 1'b1, 1'b0, 8'h00));
    // line watch off and sends refused during a frame
    send_request(make_req(ACT_LINE, 1'b0, 1'b0, 8'h00));
    send_request(make_req(ACT_SEND, 1'b1, 1'b0, 8'h5A));
    send_request(make_req(ACT_TICK, 1'b1, 1'b0, 8'h00));
    send_request(make_req(ACT_TICK, 1'b1, 1'b1, 8'h00));
    // receive cut off by host
    send_request(make_req(ACT_TICK, 1'b0, 1'b1, 8'h00));
    // send cut off by host
    send_request(make_req(ACT_SEND, 1'b1, 1'b0, 8'hFF));
    send_request(make_req(ACT_TICK, 1'b1, 1'b0, 8'h00));
    send_request(make_req(ACT_TICK, 1'b0, 1'b0, 8'h00));
    send_request(make_req(ACT_SEND, 1'b1, 1'b1, 8'h80));
    send_request(make_req(ACT_TICK, 1'b1, 1'b1, 8'h00));
    send_request(make_req(ACT_TICK, 1'b0, 1'b1, 8'h00));
  endtask

  task automatic test_send_frames(input int frames);
    for (int f = 0; f < frames; f++) begin
      calm = ($urandom_range(0, 3) == 0);
      send_request(make_req(ACT_SEND, 1'b1, 1'($urandom_range(0, 1)),
                            8'($urandom_range(1, 255))));
      clock_frame($urandom_range(0, 5) == 0);
    end
    calm = 1'b0;
  endtask

  task automatic test_receive_frames(input int frames);
    for (int f = 0; f < frames; f++) begin
      calm = ($urandom_range(0, 3) == 0);
      send_request(make_req(ACT_LINE, 1'b0, 1'b0, 8'($urandom())));
      if ($urandom_range(0, 4) == 0)
        send_request(make_req(ACT_LINE, 1'b1, 1'b1, 8'($urandom())));
      send_request(make_req(ACT_LINE, 1'b1, 1'b0, 8'($urandom())));
      clock_frame($urandom_range(0, 5) == 0);
    end
    calm = 1'b0;
  endtask

  // Sends refused while disabled; reception still works
  task automatic test_disabled();
    write_enable(1'b0);
    for (int i = 0; i < 6; i++)
      send_request(make_req(ACT_SEND, 1'b1, 1'($urandom_range(0, 1)),
                            8'($urandom_range(1, 255))));
    test_receive_frames(2);
    write_enable(1'b1);
  endtask

  // Unstructured requests, weighted towards ticks
  task automatic test_noise(input int count);
    action_e act;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: act = ACT_TICK;
        5, 6:          act = ACT_LINE;
        7, 8:          act = ACT_SEND;
        default:       act = ACT_NONE;
      endcase
      send_request(make_req(act, 1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom())));
    end
    calm = 1'b0;
  endtask

  // Result side stalls for a drawn number of cycles after each result
  always @(posedge clk_i) begin
    if (out_stall_i) begin
      stall_left--;
      if (stall_left <= 0) out_stall_i <= 1'b0;
    end else if (rst_ni && out_valid_o) begin
      stall_left = draw_gap();
      if (stall_left > 0) out_stall_i <= 1'b1;
    end
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    bit        bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("%0t: response with nothing outstanding: %h", $realtime, out_item_o);
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        bad = (out_item_o.clk_drive_low  !== want.clk_drive_low)  ||
              (out_item_o.data_drive_low !== want.data_drive_low) ||
              (out_item_o.rx_valid       !== want.rx_valid)       ||
              (out_item_o.rx_byte        !== want.rx_byte)        ||
              (out_item_o.rx_parity_bit  !== want.rx_parity_bit)  ||
              (out_item_o.send_accepted  !== want.send_accepted)  ||
              (out_item_o.tx_done        !== want.tx_done)        ||
              (out_item_o.tx_aborted     !== want.tx_aborted)     ||
              (out_item_o.busy_res       !== want.busy_res);
        if (bad) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("%0t: response %0d wrong: exp ck=%b dt=%b rv=%b rb=%h rp=%b sa=%b td=%b ta=%b bz=%b",
                     $realtime, responses_checked,
                     want.clk_drive_low, want.data_drive_low, want.rx_valid,
                     want.rx_byte, want.rx_parity_bit, want.send_accepted,
                     want.tx_done, want.tx_aborted, want.busy_res);
            $display("    got ck=%b dt=%b rv=%b rb=%h rp=%b sa=%b td=%b ta=%b bz=%b",
                     out_item_o.clk_drive_low, out_item_o.data_drive_low,
                     out_item_o.rx_valid, out_item_o.rx_byte, out_item_o.rx_parity_bit,
                     out_item_o.send_accepted, out_item_o.tx_done,
                     out_item_o.tx_aborted, out_item_o.busy_res);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d responses outstanding",
               $realtime, pending_responses.size());
      $display("** ps2_device_link_transceiver_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cycle_count = 0;
    calm        = 1'b0;
    dev_enable  = DEVICE_ENABLED_RST;
    clk_freed   = 1'b1;
    frame_pos   = '0;
    rx_active   = 1'b0;
    tx_active   = 1'b0;
    rts_seen    = 1'b0;
    rx_sreg     = '0;
    rx_par      = 1'b0;
    tx_sreg     = '0;
    tx_par      = 1'b0;
    data_held_low = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_enable(1'b1);
    test_directed();
    test_send_frames(14);
    test_receive_frames(14);
    test_disabled();
    test_noise(220);
    test_send_frames(4);
    test_receive_frames(4);

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d requests and checked %0d responses: %0d frames sent, %0d bytes received,",
             requests_sent, responses_checked, frames_started, bytes_received);
    $display("%0d sends cut off by the host, %0d errors, %0d responses never seen.",
             frames_cut, error_count, pending_responses.size());
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("** ps2_device_link_transceiver_unit: PASSED **");
    end else begin
      $display("** ps2_device_link_transceiver_unit: FAILED **");
    end
    $finish;
  end

endmodule
